// ===== rtl/core/nmot_pkg.sv =====
// package: types and constants for the nearest-match object tracker
package nmot_pkg;

  localparam int MaxTracks = 16;
  localparam int IdxW = $clog2(MaxTracks);
  localparam int CntW = $clog2(MaxTracks + 1);

  localparam logic [2:0] REG_MIN_CONF = 3'd0;
  localparam logic [2:0] REG_MIN_AREA = 3'd1;
  localparam logic [2:0] REG_MAX_MOVE = 3'd2;
  localparam logic [2:0] REG_MIN_MOVE = 3'd3;
  localparam logic [2:0] REG_INACTIVE = 3'd4;
  localparam logic [2:0] REG_EXPIRY   = 3'd5;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now;
    logic        class_match;
    logic [15:0] confidence;
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
  } nmot_in_t;

  typedef struct packed {
    logic        detected;
    logic [4:0]  active_count;
    logic [15:0] focus_x;
    logic [15:0] focus_y;
    logic        dropped;
  } nmot_out_t;

  // one stored track
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] area;
    logic [31:0] tstamp;
  } nmot_track_t;

endpackage

// ===== rtl/core/nmot_cell.sv =====
// tracker cell: one track slot of the rotating ring
module nmot_cell (
  input  logic                  clk,
  input  logic                  shift,
  input  logic                  ins,
  input  nmot_pkg::nmot_track_t ins_d,
  input  nmot_pkg::nmot_track_t d_in,
  output nmot_pkg::nmot_track_t q
);
  import nmot_pkg::*;

  nmot_track_t q_r;

  // take the neighbor's slot, or the inserted slot (the head or a new or updated track) when inserted here
  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= ins ? ins_d : d_in;
    end
  end

  assign q = q_r;
endmodule

// ===== rtl/core/nearest_match_object_tracker.sv =====
// top level: nearest-match object tracker with a rotating ring of track cells
//
//  channel | ports                         | timing
//  in      | in_start, in_busy, in_item    | taken when start and not busy
//  out     | out_valid, out_item           | one-cycle strobe, no stall
//  cfg     | cfg_we, cfg_index, cfg_data   | written at once
//
// for an end of frame or a qualified detection the ring of cells rotates once,
// one slot per cycle past a shared distance unit at the ring head
// a detection compares each slot in the cycle it reaches the head
// an unqualified detection is taken without a scan and leaves busy low
// end of frame reinserts each kept slot below the discarded ones, so order is kept
// reset clears the control state; slot contents are undefined until written
// the receiver cannot stall; the done state after the rotation registers the report
module nearest_match_object_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_start,
  output logic                 in_busy,
  input  nmot_pkg::nmot_in_t   in_item,
  output logic                 out_valid,
  output nmot_pkg::nmot_out_t  out_item,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [16:0]          cfg_data
);
  import nmot_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  // configuration
  logic [15:0] min_conf_r, min_area_r, max_move_r, min_move_r, inactive_r;
  logic [16:0] expiry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_conf_r <= 16'd32768;
      min_area_r <= 16'd13107;
      max_move_r <= 16'd49152;
      min_move_r <= 16'd3277;
      inactive_r <= 16'd10000;
      expiry_r   <= 17'd60000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_CONF: min_conf_r <= cfg_data[15:0];
        REG_MIN_AREA: min_area_r <= cfg_data[15:0];
        REG_MAX_MOVE: max_move_r <= cfg_data[15:0];
        REG_MIN_MOVE: min_move_r <= cfg_data[15:0];
        REG_INACTIVE: inactive_r <= cfg_data[15:0];
        REG_EXPIRY:   expiry_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and per-item registers
  state_t             state_r;
  logic [CntW-1:0]    count_r, kept_r;
  logic [CntW-1:0]    step_r;
  logic               cmd_r, matched_r;
  logic [31:0]        now_r;
  logic [15:0]        cx_r, cy_r, area_r;
  logic [32:0]        maxsq_r, minsq_r;
  logic               seen_r, drop_r;
  logic [15:0]        fx_r, fy_r, best_r;
  logic [CntW-1:0]    active_r;

  // ring of cells: cell k feeds cell k-1, head is cell 0
  nmot_track_t cell_q [MaxTracks];
  nmot_track_t tail_in;
  logic        shift;

  // insertion point: the tail for a detection; for end of frame it sits
  // one cell lower for every slot discarded so far
  logic [CntW-1:0] gap;
  logic [IdxW-1:0] ins_pos;
  logic            ins_en;

  for (genvar k = 0; k < MaxTracks; k++) begin : g_ring
    nmot_cell u_cell (
      .clk  (clk),
      .shift(shift),
      .ins  (ins_en && (ins_pos == IdxW'(k))),
      .ins_d(tail_in),
      .d_in (cell_q[(k + 1) % MaxTracks]),
      .q    (cell_q[k])
    );
  end

  // ring head evaluation
  nmot_track_t head;
  logic [15:0] dx, dy;
  logic [31:0] dx_sq, dy_sq;
  logic [32:0] sq_dist;
  logic        in_slot, hit, moved, expired, is_active;
  logic [31:0] age;

  assign head    = cell_q[0];
  assign in_slot = (step_r < count_r);
  assign dx      = (cx_r > head.x) ? cx_r - head.x : head.x - cx_r;
  assign dy      = (cy_r > head.y) ? cy_r - head.y : head.y - cy_r;
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign sq_dist = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign hit     = in_slot && !matched_r && (sq_dist < maxsq_r);
  assign moved   = sq_dist > minsq_r;
  assign age     = now_r - head.tstamp;
  assign expired = age > {15'd0, expiry_r};
  assign is_active = age < {16'd0, inactive_r};

  assign gap     = step_r - kept_r;
  assign ins_pos = cmd_r ? IdxW'(MaxTracks - 1) - gap[IdxW-1:0] : IdxW'(MaxTracks - 1);
  assign ins_en  = !cmd_r || (in_slot && !expired);

  // detection qualification at the input
  logic [31:0] prod;
  logic [16:0] cx_s, cy_s;
  logic [31:0] max_sq, min_sq;
  logic        qual;
  assign prod   = in_item.box_w * in_item.box_h;
  assign cx_s   = {1'b0, in_item.box_x} + {2'b0, in_item.box_w[15:1]};
  assign cy_s   = {1'b0, in_item.box_y} + {2'b0, in_item.box_h[15:1]};
  assign max_sq = max_move_r * max_move_r;
  assign min_sq = min_move_r * min_move_r;
  assign qual   = in_item.class_match && (in_item.confidence >= min_conf_r)
                  && (prod[31:16] > min_area_r);

  // what is inserted while scanning
  always_comb begin
    tail_in = head;
    if (!cmd_r && hit) begin
      tail_in.x    = cx_r;
      tail_in.y    = cy_r;
      tail_in.area = area_r;
      if (moved) tail_in.tstamp = now_r;
    end
    if (!cmd_r && !matched_r && !hit && step_r == count_r
        && count_r < CntW'(MaxTracks)) begin
      tail_in.x      = cx_r;
      tail_in.y      = cy_r;
      tail_in.area   = area_r;
      tail_in.tstamp = now_r;
    end
  end

  // the ring rotates one slot per cycle while scanning
  assign shift = (state_r == ST_SCAN);

  assign in_busy = (state_r != ST_IDLE);

  logic [4:0] act_rep;
  assign act_rep = (active_r > CntW'(31)) ? 5'd31 : 5'(active_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      seen_r    <= 1'b0;
      drop_r    <= 1'b0;
      fx_r      <= '0;
      fy_r      <= '0;
      out_valid <= 1'b0;
      step_r    <= '0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_start) begin
            cmd_r     <= in_item.cmd;
            now_r     <= in_item.now;
            cx_r      <= cx_s[16] ? 16'hFFFF : cx_s[15:0];
            cy_r      <= cy_s[16] ? 16'hFFFF : cy_s[15:0];
            area_r    <= prod[31:16];
            maxsq_r   <= {1'b0, max_sq};
            minsq_r   <= {1'b0, min_sq};
            matched_r <= 1'b0;
            kept_r    <= '0;
            active_r  <= '0;
            best_r    <= '0;
            step_r    <= '0;
            if (in_item.cmd || qual) begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          step_r <= step_r + 1'b1;
          if (cmd_r) begin
            if (in_slot && !expired) begin
              kept_r <= kept_r + 1'b1;
              if (is_active) begin
                active_r <= active_r + 1'b1;
                if (head.area > best_r) begin
                  best_r <= head.area;
                  fx_r   <= head.x;
                  fy_r   <= head.y;
                end
              end
            end
          end else begin
            seen_r <= 1'b1;
            if (hit) matched_r <= 1'b1;
          end
          if (step_r == CntW'(MaxTracks - 1)) state_r <= ST_DONE;
        end
        default: begin
          state_r <= ST_IDLE;
          if (cmd_r) begin
            count_r   <= kept_r;
            out_valid <= 1'b1;
            out_item  <= '{detected: seen_r && active_r != '0,
                           active_count: act_rep, focus_x: fx_r,
                           focus_y: fy_r, dropped: drop_r};
            seen_r    <= 1'b0;
            drop_r    <= 1'b0;
          end else if (!matched_r) begin
            if (count_r < CntW'(MaxTracks)) count_r <= count_r + 1'b1;
            else drop_r <= 1'b1;
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxTracks)) else $error("track count overflow");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_IDLE) else $error("result outside idle");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid)) else $error("double result");
`endif
endmodule

// ===== tb/tb.sv =====
// testbench for the nearest-match object tracker: random frames checked against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nmot_pkg::*;

  localparam int Latency = MaxTracks + 8;

  // scoreboard: tracker prediction plus queue of expected frame reports
  class frame_report_board;
    logic [15:0] min_conf, min_area, max_move, min_move, inactive_ms;
    logic [16:0] expiry_ms;
    int unsigned count;
    logic [15:0] tx[MaxTracks], ty[MaxTracks], tarea[MaxTracks];
    logic [31:0] ttime[MaxTracks];
    bit seen, dropped;
    logic [15:0] fx, fy;
    nmot_out_t pending[$];
    int errors;

    function void reset_state();
      min_conf = 16'd32768; min_area = 16'd13107; max_move = 16'd49152;
      min_move = 16'd3277; inactive_ms = 16'd10000; expiry_ms = 17'd60000;
      count = 0; seen = 0; dropped = 0; fx = 0; fy = 0;
      pending.delete(); errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [16:0] v);
      case (idx)
        REG_MIN_CONF: min_conf = v[15:0];
        REG_MIN_AREA: min_area = v[15:0];
        REG_MAX_MOVE: max_move = v[15:0];
        REG_MIN_MOVE: min_move = v[15:0];
        REG_INACTIVE: inactive_ms = v[15:0];
        REG_EXPIRY:   expiry_ms = v;
        default: ;
      endcase
    endfunction

    function logic [15:0] centre(logic [15:0] pos, logic [15:0] size);
      logic [16:0] s;
      s = pos + (size >> 1);
      return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function void note_item(nmot_in_t it);
      logic [31:0] prod;
      logic [15:0] ar, cx, cy;
      logic [33:0] d, maxsq, minsq;
      logic [16:0] dx, dy;
      int unsigned k, act, best;
      nmot_out_t r;
      if (!it.cmd) begin
        if (!it.class_match || it.confidence < min_conf) return;
        prod = it.box_w * it.box_h;
        ar = prod[31:16];
        if (ar <= min_area) return;
        seen = 1;
        cx = centre(it.box_x, it.box_w);
        cy = centre(it.box_y, it.box_h);
        maxsq = max_move * max_move;
        minsq = min_move * min_move;
        for (int i = 0; i < count; i++) begin
          dx = (cx > tx[i]) ? cx - tx[i] : tx[i] - cx;
          dy = (cy > ty[i]) ? cy - ty[i] : ty[i] - cy;
          d = dx * dx + dy * dy;
          if (d < maxsq) begin
            if (d > minsq) ttime[i] = it.now;
            tx[i] = cx; ty[i] = cy; tarea[i] = ar;
            return;
          end
        end
        if (count < MaxTracks) begin
          tx[count] = cx; ty[count] = cy; tarea[count] = ar; ttime[count] = it.now;
          count++;
        end else dropped = 1;
        return;
      end
      // end of frame: expire in order, then scan for active and largest
      k = 0;
      for (int i = 0; i < count; i++) begin
        if (it.now - ttime[i] > {15'd0, expiry_ms}) continue;
        tx[k] = tx[i]; ty[k] = ty[i]; tarea[k] = tarea[i]; ttime[k] = ttime[i];
        k++;
      end
      count = k;
      act = 0; best = 0;
      for (int i = 0; i < count; i++)
        if (it.now - ttime[i] < {16'd0, inactive_ms}) begin
          act++;
          if (tarea[i] > best) begin
            best = tarea[i]; fx = tx[i]; fy = ty[i];
          end
        end
      r.detected = seen && act != 0;
      r.active_count = act[4:0];
      r.focus_x = fx; r.focus_y = fy;
      r.dropped = dropped;
      pending.push_back(r);
      seen = 0; dropped = 0;
    endfunction

    function void check_report(nmot_out_t got);
      nmot_out_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected report %p", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_start = 0, in_busy;
  nmot_in_t in_item = '0;
  logic out_valid;
  nmot_out_t out_item;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  frame_report_board board = new();
  int idle_pct = 31;
  logic [31:0] frame_ms = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  nearest_match_object_tracker u_dut (.*);

  // every report is taken in the cycle it is strobed
  always @(posedge clk)
    if (rst_n && out_valid) board.check_report(out_item);

  // start stays high between back-to-back transactions
  task automatic send(nmot_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_start <= 0;
      @(posedge clk);
    end
    in_start <= 1;
    in_item <= it;
    @(posedge clk);
    while (in_busy) @(posedge clk);
    board.note_item(it);
  endtask

  task automatic drain();
    in_start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [16:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    board.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // detection near a cluster of positions so tracks get matched and moved
  function automatic nmot_in_t detection(bit wild);
    nmot_in_t it;
    it = '0;
    it.cmd = 0;
    it.now = frame_ms;
    it.class_match = 1'(wild ? $urandom_range(1) : ($urandom_range(9) != 0));
    it.confidence = 16'(wild ? $urandom : $urandom_range(65535, 20000));
    it.box_w = 16'(wild ? $urandom : $urandom_range(65535, 15000));
    it.box_h = 16'(wild ? $urandom : $urandom_range(65535, 15000));
    it.box_x = 16'(wild ? $urandom : $urandom_range(3) * 16000 + $urandom_range(3000));
    it.box_y = 16'(wild ? $urandom : $urandom_range(3) * 16000 + $urandom_range(3000));
    return it;
  endfunction

  task automatic end_frame();
    nmot_in_t it;
    it = '0;
    it.cmd = 1;
    it.now = frame_ms;
    it.class_match = 1'($urandom_range(1));
    it.confidence = 16'($urandom); it.box_x = 16'($urandom); it.box_y = 16'($urandom);
    it.box_w = 16'($urandom); it.box_h = 16'($urandom);
    send(it);
    // frames step by a few seconds, sometimes long jumps to expire tracks
    case ($urandom_range(9))
      0: frame_ms = frame_ms + $urandom_range(120000, 20000);
      1: frame_ms = $urandom;
      default: frame_ms = frame_ms + $urandom_range(4000);
    endcase
  endtask

  task automatic run_frames(int n_items, bit loose);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(loose ? 20 : 6)) begin
        send(detection($urandom_range(9) == 0));
        sent++;
      end
      end_frame();
      sent++;
    end
  endtask

  initial begin
    nmot_in_t it;
    board.reset_state();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, qualification edges, saturated centre, full table
    it = '0; it.class_match = 1; it.confidence = 16'hFFFF;
    it.box_x = 16'hFFFF; it.box_y = 16'hFFFF; it.box_w = 16'hFFFF; it.box_h = 16'hFFFF;
    send(it);
    it.now = 32'hFFFF_FFFF; it.box_x = 0; it.box_y = 0; send(it);
    it.class_match = 0; send(it);
    it.class_match = 1; it.confidence = 16'd32767; send(it);
    it.confidence = 16'd32768; it.box_w = 16'd13107; it.box_h = 16'hFFFF; send(it);
    it.cmd = 1; send(it);
    it = '0; it.cmd = 1; send(it);
    drain();
    set_reg(REG_MAX_MOVE, 17'd0);
    set_reg(REG_MIN_AREA, 17'd0);
    set_reg(REG_MIN_CONF, 17'd0);
    for (int i = 0; i < 18; i++) begin
      it = '0; it.class_match = 1; it.now = i;
      it.box_x = 16'(i * 3000); it.box_y = 16'(i * 1000);
      it.box_w = 16'(4000 + i * 100); it.box_h = 16'hFFFF;
      send(it);
    end
    it = '0; it.cmd = 1; it.now = 32'd5; send(it);
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin
          set_reg(REG_MIN_CONF, 17'd32768); set_reg(REG_MIN_AREA, 17'd13107);
          set_reg(REG_MAX_MOVE, 17'd49152); set_reg(REG_MIN_MOVE, 17'd3277);
          set_reg(REG_INACTIVE, 17'd10000); set_reg(REG_EXPIRY, 17'd60000);
        end
        1: begin
          set_reg(REG_MIN_CONF, 17'd65535); set_reg(REG_MIN_AREA, 17'd65535);
          set_reg(REG_INACTIVE, 17'd65535); set_reg(REG_EXPIRY, 17'h1FFFF);
        end
        2: begin
          set_reg(REG_MIN_CONF, 17'd0); set_reg(REG_MIN_AREA, 17'd0);
          set_reg(REG_MAX_MOVE, 17'd65535); set_reg(REG_MIN_MOVE, 17'd0);
          set_reg(REG_INACTIVE, 17'd0); set_reg(REG_EXPIRY, 17'd0);
        end
        3: idle_pct = 0; // long stretch without gaps
        default: begin
          idle_pct = 31;
          set_reg(REG_MIN_CONF, 17'($urandom_range(40000)));
          set_reg(REG_MIN_AREA, 17'($urandom_range(20000)));
          set_reg(REG_MAX_MOVE, 17'($urandom));
          set_reg(REG_MIN_MOVE, 17'($urandom_range(8000)));
          set_reg(REG_INACTIVE, 17'($urandom_range(60000)));
          set_reg(REG_EXPIRY, 17'($urandom_range(120000)));
          set_reg(3'd7, 17'($urandom)); // unused index, ignored
        end
      endcase
      run_frames(ph == 1 ? 60 : 140, ph == 2);
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== nearest_match_object_tracker.f =====
rtl/core/nmot_pkg.sv
rtl/core/nmot_cell.sv
rtl/core/nearest_match_object_tracker.sv
tb/tb.sv
